### sv/tgps_pkg.sv
package tgps_pkg;

    localparam int PLAN_SLOTS_DEF = 32;
    localparam int GATES_DEF      = 21;
    localparam int MASK_W         = 21;
    localparam int CFG_W          = 27;
    localparam int CFG_IDX_W      = 2;

    localparam logic [19:0] MIN_NOTICE_RST      = 20'd500;
    localparam logic [23:0] MAX_PULSE_RST       = 24'd100000;
    localparam logic [26:0] CONTACT_TIMEOUT_RST = 27'd500000;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_NOTICE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_TIMEOUT = 2'd2;

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_SCHEDULE = 2'd1;
    localparam logic [1:0] KIND_CANCEL   = 2'd2;
    localparam logic [1:0] KIND_ALL_OFF  = 2'd3;

    localparam logic [2:0] RPT_OPENED    = 3'd0;
    localparam logic [2:0] RPT_CLOSED    = 3'd1;
    localparam logic [2:0] RPT_SCHED_ACK = 3'd2;
    localparam logic [2:0] RPT_CANCEL_ACK = 3'd3;
    localparam logic [2:0] RPT_ALLOFF_ACK = 3'd4;
    localparam logic [2:0] RPT_INVALID   = 3'd5;
    localparam logic [2:0] RPT_FULL      = 3'd6;
    localparam logic [2:0] RPT_WATCHDOG  = 3'd7;

    localparam logic [1:0] ST_UNUSED    = 2'd0;
    localparam logic [1:0] ST_SCHEDULED = 2'd1;
    localparam logic [1:0] ST_OPEN      = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] now_time;
        logic [31:0] request_id;
        logic [31:0] plan_seq;
        logic [31:0] plan_gates;
        logic [63:0] open_at;
        logic [63:0] close_at;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        report;
        logic [31:0]       echo_request;
        logic [31:0]       echo_seq;
        logic [MASK_W-1:0] mask_out;
        logic [63:0]       stamp;
        logic [MASK_W-1:0] driven_gates;
        logic              final_one;
    } result_t;

    // Request from the sequencer to the gate counter unit.
    typedef struct packed {
        logic       go_open;
        logic       go_close;
        logic       clear;
        logic [31:0] mask;
    } gate_req_t;

endpackage

### sv/tgps_gates.sv
module tgps_gates #(
    parameter int GATES = tgps_pkg::GATES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tgps_pkg::gate_req_t req,
    output logic [GATES-1:0]    driven
);
    import tgps_pkg::*;

    logic [7:0]       count_reg [GATES];
    logic [GATES-1:0] driven_reg;

    // All gates are updated in parallel; each lane is independent.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            driven_reg <= '0;
            for (int g = 0; g < GATES; g++)
            begin
                count_reg[g] <= 8'd0;
            end
        end
        else if (req.clear)
        begin
            driven_reg <= '0;
            for (int g = 0; g < GATES; g++)
            begin
                count_reg[g] <= 8'd0;
            end
        end
        else
        begin
            for (int g = 0; g < GATES; g++)
            begin
                if (req.mask[g] && req.go_open)
                begin
                    if (count_reg[g] != 8'd255)
                    begin
                        count_reg[g] <= count_reg[g] + 8'd1;
                    end
                    driven_reg[g] <= 1'b1;
                end
                else if (req.mask[g] && req.go_close)
                begin
                    if (count_reg[g] > 8'd1)
                    begin
                        count_reg[g] <= count_reg[g] - 8'd1;
                    end
                    else
                    begin
                        count_reg[g] <= 8'd0;
                        driven_reg[g] <= 1'b0;
                    end
                end
            end
        end
    end

    assign driven = driven_reg;

endmodule

### sv/timed_gate_pulse_scheduler.sv
// Timed gate pulse scheduler.
// A command transaction (tick, schedule, cancel or all-off) is taken at a rising
// edge with start high and busy low; busy then stays high until the command is done.
// Each result transaction sits on result for exactly one cycle with result_valid
// high, and the last result of a command has final_one set. The receiver cannot
// stall, so nothing ever waits on the result side.
// Configuration registers are written through cfg_we, cfg_index and cfg_data;
// the user must write them only while busy is low; the block does not enforce it.
// Timing: one shared 64-bit comparator walks the plan table a slot per cycle
// while no plan opens, is open or closes. A tick scans every slot, opening
// due plans and closing due open ones, then checks the watchdog, with a flush
// step when it reports. Tick events are held one stage so that the last one
// can carry final_one; each leaves when the next is found or when the scan
// ends. A schedule passes VAL1 and VAL2, then for a valid plan searches every
// slot and writes it or reports full; a cancel searches up to its plan or the
// last slot, then DONE; an all-off goes to DONE. The last result shows in the
// cycle after busy falls, and the next command may be taken in that same cycle.
// Reset clears every slot to unused, all gate counts, the driven mask, the
// contact time and the watchdog flag, and loads the register defaults.
module timed_gate_pulse_scheduler #(
    parameter int PLAN_SLOTS = tgps_pkg::PLAN_SLOTS_DEF,
    parameter int GATES      = tgps_pkg::GATES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  tgps_pkg::cmd_t                   cmd,
    output logic                             result_valid,
    output tgps_pkg::result_t                result,
    input  logic                             cfg_we,
    input  logic [tgps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgps_pkg::CFG_W-1:0]       cfg_data
);
    import tgps_pkg::*;

    localparam int SW = (PLAN_SLOTS > 1) ? $clog2(PLAN_SLOTS) : 1;
    localparam logic [SW-1:0] LAST = SW'(PLAN_SLOTS - 1);

    // Sequencer states, one-hot.
    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_TSCAN   = 13'b0000000000010,
        S_TOPEN   = 13'b0000000000100,
        S_TCLOSE  = 13'b0000000001000,
        S_TCLOSED = 13'b0000000010000,
        S_WDOG    = 13'b0000000100000,
        S_FLUSH   = 13'b0000001000000,
        S_VAL1    = 13'b0000010000000,
        S_VAL2    = 13'b0000100000000,
        S_SSEARCH = 13'b0001000000000,
        S_SWRITE  = 13'b0010000000000,
        S_CSEARCH = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [19:0] min_notice_reg;
    logic [23:0] max_pulse_reg;
    logic [26:0] contact_timeout_reg;

    logic [1:0]  status_reg [PLAN_SLOTS];
    logic [31:0] seq_mem    [PLAN_SLOTS];
    logic [GATES-1:0] gates_mem [PLAN_SLOTS];
    logic [63:0] open_mem   [PLAN_SLOTS];
    logic [63:0] close_mem  [PLAN_SLOTS];

    cmd_t        cmd_reg;
    logic [SW-1:0] idx_reg;
    logic [63:0] last_contact_reg;
    logic        tripped_reg;
    logic        bad_reg;
    logic        found_reg;
    logic [SW-1:0] hit_reg;
    logic        free_ok_reg;
    logic [SW-1:0] free_reg;
    logic        any_used_reg;

    logic        res_valid_reg;
    result_t     res_reg;
    logic        hold_valid_reg;
    result_t     hold_reg;

    gate_req_t   greq;
    logic [GATES-1:0] driven;

    // Shared comparator: one 64-bit "a >= b" per cycle.
    logic [63:0] cmp_a, cmp_b;
    logic        cmp_ge;
    logic [64:0] cmp_diff;
    assign cmp_diff = {1'b0, cmp_a} - {1'b0, cmp_b};
    assign cmp_ge   = !cmp_diff[64];

    logic [SW-1:0] idx;
    assign idx = idx_reg;

    logic [1:0] cur_status;
    assign cur_status = status_reg[idx];

    logic [63:0] plan_len;
    logic [64:0] notice_sum;
    assign plan_len   = cmd_reg.close_at - cmd_reg.open_at;
    assign notice_sum = {1'b0, cmd_reg.now_time} + 65'(min_notice_reg);

    // The second half of plan validation, checked in the cycle that decides.
    logic span_bad;
    assign span_bad = (cmd_reg.close_at <= cmd_reg.open_at) ||
                      (plan_len > 64'(max_pulse_reg));

    // The watchdog trips when the host has been silent too long.
    logic wd_fire;
    assign wd_fire = !tripped_reg &&
                     ((cmd_reg.now_time - last_contact_reg) > 64'(contact_timeout_reg));

    logic [GATES-1:0] mask_inval_src;
    logic [31:0] gate_bits;
    assign gate_bits = (GATES >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << GATES) - 64'd1);
    assign mask_inval_src = cmd_reg.plan_gates[GATES-1:0];

    always_comb
    begin
        cmp_a = cmd_reg.now_time;
        cmp_b = open_mem[idx];
        if (state_reg == S_TCLOSE)
        begin
            cmp_b = close_mem[idx];
        end
    end

    tgps_gates #(.GATES(GATES)) u_gates (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (greq),
        .driven (driven)
    );

    logic emit;
    logic [2:0] e_rep;
    logic [31:0] e_req, e_seq;
    logic [MASK_W-1:0] e_mask;
    logic [MASK_W-1:0] e_drv;
    logic e_last;

    result_t e_data;
    result_t out_data;
    logic    out_fire;
    logic    hold_load;
    logic    hold_valid_next;

    function automatic logic [MASK_W-1:0] fit(input logic [GATES-1:0] m);
        logic [31:0] w;
        w = 32'(m);
        return w[MASK_W-1:0];
    endfunction

    always_comb
    begin
        state_next = state_reg;
        greq = '0;
        emit = 1'b0;
        e_rep = RPT_OPENED;
        e_req = '0;
        e_seq = '0;
        e_mask = '0;
        e_drv = fit(driven);
        e_last = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd.kind)
                        KIND_TICK:     state_next = S_TSCAN;
                        KIND_SCHEDULE: state_next = S_VAL1;
                        KIND_CANCEL:   state_next = S_CSEARCH;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_TSCAN:
            begin
                if (cur_status == ST_SCHEDULED && cmp_ge)
                begin
                    state_next = S_TOPEN;
                    greq.go_open = 1'b1;
                    greq.mask = 32'(gates_mem[idx]);
                end
                else if (cur_status == ST_OPEN)
                begin
                    state_next = S_TCLOSE;
                end
                else if (idx_reg == LAST)
                begin
                    state_next = S_WDOG;
                end
            end
            S_TOPEN:
            begin
                // Gate counters have absorbed the open; report it now.
                emit = 1'b1;
                e_rep = RPT_OPENED;
                e_seq = seq_mem[idx];
                e_mask = fit(gates_mem[idx]);
                state_next = S_TCLOSE;
            end
            S_TCLOSE:
            begin
                if (cmp_ge)
                begin
                    greq.go_close = 1'b1;
                    greq.mask = 32'(gates_mem[idx]);
                    state_next = S_TCLOSED;
                end
                else if (idx_reg == LAST)
                begin
                    state_next = S_WDOG;
                end
                else
                begin
                    state_next = S_TSCAN;
                end
            end
            S_TCLOSED:
            begin
                // Gate counters have absorbed the close; report it now.
                emit = 1'b1;
                e_rep = RPT_CLOSED;
                e_seq = seq_mem[idx];
                e_mask = fit(gates_mem[idx]);
                if (idx_reg == LAST)
                begin
                    state_next = S_WDOG;
                end
                else
                begin
                    state_next = S_TSCAN;
                end
            end
            S_WDOG:
            begin
                state_next = S_IDLE;
                if (wd_fire)
                begin
                    greq.clear = 1'b1;
                end
                if (wd_fire && (any_used_reg || driven != '0))
                begin
                    emit = 1'b1;
                    e_rep = RPT_WATCHDOG;
                    e_mask = fit(driven);
                    e_drv = '0;
                    state_next = S_FLUSH;
                end
                else
                begin
                    e_last = 1'b1;
                end
            end
            S_FLUSH:
            begin
                e_last = 1'b1;
                state_next = S_IDLE;
            end
            S_VAL1:
            begin
                state_next = S_VAL2;
            end
            S_VAL2:
            begin
                if (bad_reg || span_bad)
                begin
                    emit = 1'b1;
                    e_rep = RPT_INVALID;
                    e_req = cmd_reg.request_id;
                    e_last = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SSEARCH;
                end
            end
            S_SSEARCH:
            begin
                if (idx_reg == LAST)
                begin
                    state_next = S_SWRITE;
                end
            end
            S_SWRITE:
            begin
                emit = 1'b1;
                e_req = cmd_reg.request_id;
                e_last = 1'b1;
                if (found_reg || free_ok_reg)
                begin
                    e_rep = RPT_SCHED_ACK;
                    e_seq = cmd_reg.plan_seq;
                end
                else
                begin
                    e_rep = RPT_FULL;
                end
                state_next = S_IDLE;
            end
            S_CSEARCH:
            begin
                if (cur_status != ST_UNUSED && seq_mem[idx] == cmd_reg.plan_seq)
                begin
                    if (cur_status == ST_OPEN)
                    begin
                        greq.go_close = 1'b1;
                        greq.mask = 32'(gates_mem[idx]);
                    end
                    state_next = S_DONE;
                end
                else if (idx_reg == LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                emit = 1'b1;
                e_req = cmd_reg.request_id;
                e_last = 1'b1;
                if (cmd_reg.kind == KIND_CANCEL)
                begin
                    e_rep = RPT_CANCEL_ACK;
                    e_seq = cmd_reg.plan_seq;
                end
                else
                begin
                    e_rep = RPT_ALLOFF_ACK;
                    greq.clear = 1'b1;
                    e_drv = '0;
                end
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result path. A command's single result goes straight out as the final
    // one. Tick results wait in a one-entry hold: a new event pushes the held
    // one out as not final, and the end of the scan sends the held one out as
    // final.
    always_comb
    begin
        e_data.report       = e_rep;
        e_data.echo_request = e_req;
        e_data.echo_seq     = e_seq;
        e_data.mask_out     = e_mask;
        e_data.stamp        = cmd_reg.now_time;
        e_data.driven_gates = e_drv;
        e_data.final_one    = e_last;
        out_fire        = 1'b0;
        out_data        = hold_reg;
        hold_load       = 1'b0;
        hold_valid_next = hold_valid_reg;
        if (emit && e_last)
        begin
            out_fire = 1'b1;
            out_data = e_data;
        end
        else if (emit)
        begin
            out_fire = hold_valid_reg;
            out_data.final_one = 1'b0;
            hold_load = 1'b1;
            hold_valid_next = 1'b1;
        end
        else if (e_last)
        begin
            out_fire = hold_valid_reg;
            out_data.final_one = 1'b1;
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            min_notice_reg <= MIN_NOTICE_RST;
            max_pulse_reg <= MAX_PULSE_RST;
            contact_timeout_reg <= CONTACT_TIMEOUT_RST;
            last_contact_reg <= '0;
            tripped_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            res_reg <= '0;
            hold_valid_reg <= 1'b0;
            hold_reg <= '0;
            cmd_reg <= '0;
            bad_reg <= 1'b0;
            found_reg <= 1'b0;
            hit_reg <= '0;
            free_ok_reg <= 1'b0;
            free_reg <= '0;
            any_used_reg <= 1'b0;
            idx_reg <= '0;
            for (int i = 0; i < PLAN_SLOTS; i++)
            begin
                status_reg[i] <= ST_UNUSED;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_NOTICE:      min_notice_reg <= cfg_data[19:0];
                    REG_MAX_PULSE:       max_pulse_reg <= cfg_data[23:0];
                    REG_CONTACT_TIMEOUT: contact_timeout_reg <= cfg_data[26:0];
                    default: ;
                endcase
            end

            res_valid_reg <= out_fire;
            if (out_fire)
            begin
                res_reg <= out_data;
            end
            hold_valid_reg <= hold_valid_next;
            if (hold_load)
            begin
                hold_reg <= e_data;
            end

            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (start)
                    begin
                        cmd_reg <= cmd;
                        any_used_reg <= 1'b0;
                        found_reg <= 1'b0;
                        free_ok_reg <= 1'b0;
                        if (cmd.kind != KIND_TICK)
                        begin
                            last_contact_reg <= cmd.now_time;
                            tripped_reg <= 1'b0;
                        end
                    end
                end
                S_TSCAN:
                begin
                    if (cur_status == ST_SCHEDULED && cmp_ge)
                    begin
                        status_reg[idx] <= ST_OPEN;
                    end
                    else
                    begin
                        // Open slots are judged in the close step instead.
                        if (cur_status == ST_SCHEDULED)
                        begin
                            any_used_reg <= 1'b1;
                        end
                        if (cur_status != ST_OPEN && idx_reg != LAST)
                        begin
                            idx_reg <= idx_reg + SW'(1);
                        end
                    end
                end
                S_TCLOSE:
                begin
                    if (cmp_ge)
                    begin
                        status_reg[idx] <= ST_UNUSED;
                    end
                    else
                    begin
                        any_used_reg <= 1'b1;
                        if (idx_reg != LAST)
                        begin
                            idx_reg <= idx_reg + SW'(1);
                        end
                    end
                end
                S_TCLOSED:
                begin
                    if (idx_reg != LAST)
                    begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_WDOG:
                begin
                    if (wd_fire)
                    begin
                        tripped_reg <= 1'b1;
                        for (int i = 0; i < PLAN_SLOTS; i++)
                        begin
                            status_reg[i] <= ST_UNUSED;
                        end
                    end
                end
                S_VAL1:
                begin
                    bad_reg <= (cmd_reg.plan_gates == 32'd0) ||
                               ((cmd_reg.plan_gates & ~gate_bits) != 32'd0) ||
                               (mask_inval_src == '0) ||
                               ({1'b0, cmd_reg.open_at} < notice_sum);
                end
                S_SSEARCH:
                begin
                    if (cur_status != ST_UNUSED && seq_mem[idx] == cmd_reg.plan_seq &&
                        !found_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg <= idx;
                    end
                    if (cur_status == ST_UNUSED && !free_ok_reg)
                    begin
                        free_ok_reg <= 1'b1;
                        free_reg <= idx;
                    end
                    if (idx_reg != LAST)
                    begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_SWRITE:
                begin
                    if (found_reg)
                    begin
                        status_reg[hit_reg] <= ST_SCHEDULED;
                    end
                    else if (free_ok_reg)
                    begin
                        status_reg[free_reg] <= ST_SCHEDULED;
                    end
                end
                S_CSEARCH:
                begin
                    if (cur_status != ST_UNUSED && seq_mem[idx] == cmd_reg.plan_seq)
                    begin
                        status_reg[idx] <= ST_UNUSED;
                    end
                    else if (idx_reg != LAST)
                    begin
                        idx_reg <= idx_reg + SW'(1);
                    end
                end
                S_DONE:
                begin
                    if (cmd_reg.kind == KIND_ALL_OFF)
                    begin
                        for (int i = 0; i < PLAN_SLOTS; i++)
                        begin
                            status_reg[i] <= ST_UNUSED;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Plan fields, written only by a successful schedule.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SWRITE && (found_reg || free_ok_reg))
        begin
            seq_mem[found_reg ? hit_reg : free_reg]   <= cmd_reg.plan_seq;
            gates_mem[found_reg ? hit_reg : free_reg] <= cmd_reg.plan_gates[GATES-1:0];
            open_mem[found_reg ? hit_reg : free_reg]  <= cmd_reg.open_at;
            close_mem[found_reg ? hit_reg : free_reg] <= cmd_reg.close_at;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result = res_reg;

endmodule

### dv/timed_gate_pulse_scheduler_tb.sv
module timed_gate_pulse_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tgps_pkg::*;

    localparam int SLOTS       = PLAN_SLOTS_DEF;
    localparam int NGATES      = GATES_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_WAIT  = 60;

    // The scoreboard carries its own copy of the plan table, gate counts and
    // registers. Every accepted command transaction is run through it and
    // the results it predicts are queued in order for the result monitor.
    class gate_plan_scoreboard;
        logic [19:0]       min_notice;
        logic [23:0]       max_pulse;
        logic [26:0]       contact_timeout;
        logic [1:0]        plan_state [SLOTS];
        logic [31:0]       plan_seq_no [SLOTS];
        logic [MASK_W-1:0] plan_mask [SLOTS];
        logic [63:0]       plan_start [SLOTS];
        logic [63:0]       plan_close [SLOTS];
        int                gate_refs [NGATES];
        logic [MASK_W-1:0] driven;
        logic [63:0]       last_contact;
        bit                tripped;
        result_t           awaited [$];
        int                mismatches;

        function new();
            min_notice      = MIN_NOTICE_RST;
            max_pulse       = MAX_PULSE_RST;
            contact_timeout = CONTACT_TIMEOUT_RST;
            foreach (plan_state[i]) plan_state[i] = ST_UNUSED;
            foreach (gate_refs[g]) gate_refs[g] = 0;
            driven       = '0;
            last_contact = '0;
            tripped      = 1'b0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_MIN_NOTICE)
                min_notice = data[19:0];
            else if (idx == REG_MAX_PULSE)
                max_pulse = data[23:0];
            else if (idx == REG_CONTACT_TIMEOUT)
                contact_timeout = data[26:0];
        endfunction

        function void add_result(logic [2:0] rpt, logic [31:0] req, logic [31:0] sq,
                                 logic [MASK_W-1:0] m, logic [63:0] stamp);
            result_t r;
            r.report       = rpt;
            r.echo_request = req;
            r.echo_seq     = sq;
            r.mask_out     = m;
            r.stamp        = stamp;
            r.driven_gates = driven;
            r.final_one    = 1'b0;
            awaited.push_back(r);
        endfunction

        // Counts saturate at 255 on the way up and stop at zero going down.
        function void count_gates(logic [MASK_W-1:0] m, bit up);
            for (int g = 0; g < NGATES; g++) begin
                if (m[g]) begin
                    if (up && gate_refs[g] < 255)
                        gate_refs[g]++;
                    else if (!up && gate_refs[g] > 0)
                        gate_refs[g]--;
                    driven[g] = (gate_refs[g] != 0);
                end
            end
        endfunction

        function bit clear_table();
            bit busy_table;
            busy_table = (driven != '0);
            foreach (plan_state[i]) begin
                if (plan_state[i] != ST_UNUSED)
                    busy_table = 1'b1;
                plan_state[i] = ST_UNUSED;
            end
            foreach (gate_refs[g]) gate_refs[g] = 0;
            driven = '0;
            return busy_table;
        endfunction

        function int slot_of_seq(logic [31:0] sq);
            foreach (plan_state[i])
                if (plan_state[i] != ST_UNUSED && plan_seq_no[i] == sq)
                    return i;
            return -1;
        endfunction

        function void note_command(cmd_t c);
            int                before_n;
            int                s;
            logic [MASK_W-1:0] prev;
            bit                bad;
            before_n = awaited.size();
            if (c.kind == KIND_TICK) begin
                // Each slot may open and then close within the same tick.
                for (int i = 0; i < SLOTS; i++) begin
                    if (plan_state[i] == ST_SCHEDULED && c.now_time >= plan_start[i]) begin
                        count_gates(plan_mask[i], 1'b1);
                        plan_state[i] = ST_OPEN;
                        add_result(RPT_OPENED, '0, plan_seq_no[i], plan_mask[i], c.now_time);
                    end
                    if (plan_state[i] == ST_OPEN && c.now_time >= plan_close[i]) begin
                        count_gates(plan_mask[i], 1'b0);
                        plan_state[i] = ST_UNUSED;
                        add_result(RPT_CLOSED, '0, plan_seq_no[i], plan_mask[i], c.now_time);
                    end
                end
                if (!tripped && (c.now_time - last_contact) > 64'(contact_timeout)) begin
                    prev    = driven;
                    tripped = 1'b1;
                    if (clear_table())
                        add_result(RPT_WATCHDOG, '0, '0, prev, c.now_time);
                end
            end else begin
                last_contact = c.now_time;
                tripped      = 1'b0;
                if (c.kind == KIND_SCHEDULE) begin
                    bad = c.plan_gates == '0 || c.plan_gates[31:NGATES] != '0
                        || c.open_at < c.now_time
                        || (c.open_at - c.now_time) < 64'(min_notice)
                        || c.close_at <= c.open_at
                        || (c.close_at - c.open_at) > 64'(max_pulse);
                    if (bad) begin
                        add_result(RPT_INVALID, c.request_id, '0, '0, c.now_time);
                    end else begin
                        s = slot_of_seq(c.plan_seq);
                        if (s < 0)
                            for (int i = SLOTS - 1; i >= 0; i--)
                                if (plan_state[i] == ST_UNUSED)
                                    s = i;
                        if (s < 0) begin
                            add_result(RPT_FULL, c.request_id, '0, '0, c.now_time);
                        end else begin
                            plan_seq_no[s] = c.plan_seq;
                            plan_mask[s]   = c.plan_gates[MASK_W-1:0];
                            plan_start[s]  = c.open_at;
                            plan_close[s]  = c.close_at;
                            plan_state[s]  = ST_SCHEDULED;
                            add_result(RPT_SCHED_ACK, c.request_id, c.plan_seq, '0,
                                       c.now_time);
                        end
                    end
                end else if (c.kind == KIND_CANCEL) begin
                    s = slot_of_seq(c.plan_seq);
                    if (s >= 0) begin
                        if (plan_state[s] == ST_OPEN)
                            count_gates(plan_mask[s], 1'b0);
                        plan_state[s] = ST_UNUSED;
                    end
                    add_result(RPT_CANCEL_ACK, c.request_id, c.plan_seq, '0, c.now_time);
                end else begin
                    void'(clear_table());
                    add_result(RPT_ALLOFF_ACK, c.request_id, '0, '0, c.now_time);
                end
            end
            if (awaited.size() > before_n)
                awaited[awaited.size() - 1].final_one = 1'b1;
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            want = awaited.pop_front();
            if (got.report != want.report || got.echo_request != want.echo_request
                || got.echo_seq != want.echo_seq || got.mask_out != want.mask_out
                || got.stamp != want.stamp || got.driven_gates != want.driven_gates
                || got.final_one != want.final_one) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    gate_plan_scoreboard sb;
    int                  quiet_cycles;
    bit                  steady_send;
    logic [63:0]         t_us;
    logic [31:0]         seq_pool [6];

    timed_gate_pulse_scheduler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Monitor: both handshakes are sampled at the rising edge, before the
    // block's own updates for that edge take effect.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (start && !busy)
                sb.note_command(cmd);
            if (result_valid)
                sb.check_result(result);
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offers one command transaction and returns once it is taken. Outside the
    // steady stretch the sender leaves a short gap now and then.
    task automatic send_cmd(cmd_t c);
        if (!steady_send && $urandom_range(0, 99) < 7) begin
            @(negedge clk);
            start = 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        cmd   = c;
        do @(posedge clk); while (busy);
    endtask

    // Lets every outstanding result arrive and the block go idle, since a tick
    // may scan the table for a long while without producing anything.
    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (sb.awaited.size() != 0 || busy) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic cmd_t make_cmd(logic [1:0] k, logic [63:0] now, logic [31:0] req,
                                      logic [31:0] sq, logic [31:0] g, logic [63:0] op,
                                      logic [63:0] cl);
        cmd_t c;
        c.kind       = k;
        c.now_time   = now;
        c.request_id = req;
        c.plan_seq   = sq;
        c.plan_gates = g;
        c.open_at    = op;
        c.close_at   = cl;
        return c;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A plan that passes every check under the current registers.
    function automatic cmd_t good_plan(logic [31:0] sq, logic [31:0] g);
        logic [63:0] op;
        int unsigned span;
        op   = t_us + 64'(sb.min_notice) + 64'($urandom_range(0, 1500));
        span = (sb.max_pulse < 24'd2000) ? sb.max_pulse : 2000;
        return make_cmd(KIND_SCHEDULE, t_us, $urandom, sq, g, op,
                        op + 64'($urandom_range(1, span)));
    endfunction

    // Gate masks are either a few overlapping gates, so that counts stack, or
    // a wide random pattern within the valid gates.
    function automatic logic [31:0] plan_gates_pick();
        logic [31:0] g;
        if ($urandom_range(0, 1)) begin
            g = '0;
            repeat ($urandom_range(1, 3)) g[$urandom_range(0, NGATES - 1)] = 1'b1;
        end else begin
            g = $urandom & 32'h001F_FFFF;
            if (g == '0)
                g = 32'h1;
        end
        return g;
    endfunction

    task automatic random_phase(int count);
        int          pick;
        logic [63:0] op;
        for (int n = 0; n < count; n++) begin
            steady_send = (n >= count / 3 && n < count / 2);
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                send_cmd(good_plan(($urandom_range(0, 4) == 0) ? $urandom
                                   : seq_pool[$urandom_range(0, 5)], plan_gates_pick()));
            end else if (pick < 63) begin
                t_us += 64'($urandom_range(50, 1500));
                send_cmd(make_cmd(KIND_TICK, t_us, $urandom, $urandom, $urandom,
                                  rand64(), rand64()));
            end else if (pick < 73) begin
                send_cmd(make_cmd(KIND_CANCEL, t_us, $urandom,
                                  ($urandom_range(0, 3) == 0) ? $urandom
                                  : seq_pool[$urandom_range(0, 5)],
                                  $urandom, rand64(), rand64()));
            end else if (pick < 77) begin
                send_cmd(make_cmd(KIND_ALL_OFF, t_us, $urandom, $urandom, $urandom,
                                  rand64(), rand64()));
            end else if (pick < 84) begin
                // Fully random plan fields, nearly always rejected.
                send_cmd(make_cmd(KIND_SCHEDULE, t_us, $urandom, $urandom, $urandom,
                                  rand64(), rand64()));
            end else if (pick < 91) begin
                // Plans that miss a limit by exactly one.
                op = t_us + 64'(sb.min_notice);
                case ($urandom_range(0, 2))
                    0: send_cmd(make_cmd(KIND_SCHEDULE, t_us, $urandom, $urandom, 32'h1,
                                         op - 1, op + 1));
                    1: send_cmd(make_cmd(KIND_SCHEDULE, t_us, $urandom, $urandom, 32'h1,
                                         op, op));
                    default: send_cmd(make_cmd(KIND_SCHEDULE, t_us, $urandom, $urandom,
                                               32'h1, op, op + 64'(sb.max_pulse) + 1));
                endcase
            end else if (pick < 96) begin
                // Silence long enough for the watchdog to fire.
                t_us += 64'(sb.contact_timeout) + 64'($urandom_range(1, 1000));
                send_cmd(make_cmd(KIND_TICK, t_us, '0, '0, '0, '0, '0));
            end else begin
                // A tick from a random point in time.
                send_cmd(make_cmd(KIND_TICK, rand64(), $urandom, $urandom, $urandom,
                                  rand64(), rand64()));
            end
        end
        steady_send = 1'b0;
    endtask

    task automatic new_phase_time();
        t_us = rand64();
        if (&t_us[63:40])
            t_us[40] = 1'b0;
        foreach (seq_pool[i]) seq_pool[i] = $urandom;
    endtask

    initial
    begin
        logic [63:0] op;
        sb           = new();
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        cfg_we       = 1'b0;
        cfg_index    = REG_MIN_NOTICE;
        cfg_data     = '0;
        quiet_cycles = 0;
        steady_send  = 1'b1;
        t_us         = 64'd1000;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset values of the registers.
        send_cmd(make_cmd(KIND_TICK, '0, '0, '0, '0, '0, '0));
        op = t_us + 64'd500;
        // Exactly the least notice and exactly the longest pulse are legal.
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'hFFFF_FFFF, 32'd1, 32'h1, op,
                          op + 64'd100000));
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd2, 32'hFFFF_FFFF, 32'h0010_0000, op,
                          op + 64'd1));
        // Each way a plan can be refused.
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd3, 32'd9, 32'h0, op, op + 1));
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd4, 32'd9, 32'h0020_0000, op, op + 1));
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd5, 32'd9, 32'hFFFF_FFFF, op, op + 1));
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd6, 32'd9, 32'h1, op - 1, op + 1));
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd7, 32'd9, 32'h1, op, op));
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd8, 32'd9, 32'h1, op, op + 64'd100001));
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd9, 32'd9, 32'h1, '0, 64'd5));
        // Near the top of time the notice sum would wrap; it must still fail.
        send_cmd(make_cmd(KIND_SCHEDULE, '1, 32'd10, 32'd9, 32'h1, '1, '1));
        send_cmd(make_cmd(KIND_SCHEDULE, t_us, 32'd11, 32'd3, 32'h001F_FFFF, op + 100,
                          op + 150));
        // Opens the first two plans; then the second closes and the third opens and closes at once.
        send_cmd(make_cmd(KIND_TICK, op, '1, '1, '1, '1, '1));
        send_cmd(make_cmd(KIND_TICK, op + 200, '0, '0, '0, '0, '0));
        // Rescheduling an open plan keeps its gates counted.
        send_cmd(make_cmd(KIND_SCHEDULE, op + 200, 32'd12, 32'd1, 32'h3, op + 800,
                          op + 900));
        send_cmd(make_cmd(KIND_CANCEL, op + 200, 32'd13, 32'd1, '0, '0, '0));
        send_cmd(make_cmd(KIND_CANCEL, op + 200, 32'd14, 32'd77, '0, '0, '0));
        send_cmd(make_cmd(KIND_ALL_OFF, op + 200, 32'd15, '0, '0, '0, '0));
        send_cmd(make_cmd(KIND_SCHEDULE, op + 300, 32'd16, 32'd5, 32'h10, op + 900,
                          op + 1000));
        send_cmd(make_cmd(KIND_TICK, op + 950, '0, '0, '0, '0, '0));
        // Long silence trips the watchdog after the same tick has closed the last open
        // plan, so no gate is driven; a second tick finds it already tripped.
        send_cmd(make_cmd(KIND_TICK, op + 600000, '0, '0, '0, '0, '0));
        send_cmd(make_cmd(KIND_TICK, op + 700000, '0, '0, '0, '0, '0));
        steady_send = 1'b0;
        drain();

        // Lowest register values.
        write_reg(REG_MIN_NOTICE, '0);
        write_reg(REG_MAX_PULSE, 27'd1);
        write_reg(REG_CONTACT_TIMEOUT, 27'd1);
        new_phase_time();
        random_phase(30);
        drain();

        // High register values, with enough distinct plans to fill the table.
        write_reg(REG_MIN_NOTICE, 27'd1000000);
        write_reg(REG_MAX_PULSE, 27'd10000000);
        write_reg(REG_CONTACT_TIMEOUT, 27'd100000000);
        new_phase_time();
        send_cmd(make_cmd(KIND_ALL_OFF, t_us, $urandom, '0, '0, '0, '0));
        for (int i = 0; i < SLOTS + 2; i++)
            send_cmd(good_plan(seq_pool[0] + 32'(i) + 32'd100, plan_gates_pick()));
        random_phase(35);
        drain();

        // Middling values.
        write_reg(REG_MIN_NOTICE, 27'($urandom_range(0, 800)));
        write_reg(REG_MAX_PULSE, 27'($urandom_range(200, 3000)));
        write_reg(REG_CONTACT_TIMEOUT, 27'($urandom_range(3000, 20000)));
        new_phase_time();
        random_phase(45);
        drain();

        if (sb.mismatches == 0 && sb.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
